/* design/spdfq_pkg.sv */
`default_nettype none

package spdfq_pkg;

	localparam int CMD_W      = 2;
	localparam int TPRIO_W    = 8;
	localparam int PORT_W     = 16;
	localparam int HANDLE_W   = 16;
	localparam int STATUS_W   = 3;
	localparam int OPRIO_W    = 2;
	localparam int CAP_W      = 7;
	localparam int DELAY_W    = 20;
	localparam int REG_NUM_Q  = 4;
	localparam int REG_IDX_W  = 2;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_SEL_W  = 3;

	localparam logic [CAP_W-1:0]   CAP_RESET   = 7'd64;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd1000;

	typedef enum logic [REG_SEL_W-1:0] {
		REG_CAPACITY0 = 3'd0,
		REG_CAPACITY1 = 3'd1,
		REG_CAPACITY2 = 3'd2,
		REG_CAPACITY3 = 3'd3,
		REG_DELAY0    = 3'd4,
		REG_DELAY1    = 3'd5,
		REG_DELAY2    = 3'd6,
		REG_DELAY3    = 3'd7
	} reg_sel_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_ENQUEUE = 2'd1,
		CMD_DEQUEUE = 2'd2,
		CMD_PEEK    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_GIVEN     = 3'd3,
		ST_NONE      = 3'd4,
		ST_TICK_DONE = 3'd5
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic                has_tag;
		logic [TPRIO_W-1:0]  tag_priority;
		logic [PORT_W-1:0]   port;
		logic [HANDLE_W-1:0] packet_handle;
	} req_item_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] out_handle;
		logic [OPRIO_W-1:0]  out_priority;
	} rsp_item_t;

endpackage

`default_nettype wire

/* design/spdfq_ifs.sv */
`default_nettype none

interface spdfq_req_if;
	logic                  valid;
	logic                  ready;
	spdfq_pkg::req_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spdfq_rsp_if;
	logic                  valid;
	logic                  ready;
	spdfq_pkg::rsp_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/spdfq_mem.sv */
`default_nettype none

module spdfq_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/strict_priority_delayed_fifo_queues_core.sv */
// channel  | dir | handshake    | payload
// req      | in  | valid/ready  | cmd, has_tag, tag_priority, port, packet_handle
// rsp      | out | valid/ready  | status, out_handle, out_priority
// apb      | in  | psel/penable | capacity_prio0..3, delay_prio0..3 at 4*i
//
// tick and enqueue: accept in idle, then load of the output register in the put state
// dequeue and peek visit queues from priority 0 upward, one read state per queue visited
// and one check state (head time compare) per non-empty queue, then the put state
// req is taken in idle even while a result waits; a stalled rsp holds the next
// result in the put state
// reset clears pointers, occupancy, time and registers; entry storage is not cleared
`default_nettype none

module strict_priority_delayed_fifo_queues_core #(
	parameter int NUM_PRIORITIES = 4,
	parameter int NUM_PORTS      = 16,
	parameter int QUEUE_DEPTH    = 64,
	parameter int TIME_WIDTH     = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	spdfq_req_if.sink                             req,
	spdfq_rsp_if.source                           rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [spdfq_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [spdfq_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [spdfq_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready
);

	localparam int QW        = $clog2(NUM_PRIORITIES);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_PRIORITIES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int MEM_W     = spdfq_pkg::HANDLE_W + TIME_WIDTH;
	localparam int CMP_W     = (OCC_W > spdfq_pkg::CAP_W) ? OCC_W : spdfq_pkg::CAP_W;
	localparam int SUM_W     = TIME_WIDTH + spdfq_pkg::DELAY_W;
	localparam int PORT_CW   = spdfq_pkg::PORT_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_PUT
	} state_t;

	// configuration registers
	logic [spdfq_pkg::CAP_W-1:0]   cap_q   [spdfq_pkg::REG_NUM_Q];
	logic [spdfq_pkg::DELAY_W-1:0] delay_q [spdfq_pkg::REG_NUM_Q];
	spdfq_pkg::reg_sel_t           reg_sel;
	logic                          apb_write;

	assign pready    = 1'b1;
	assign apb_write = psel && penable && pwrite;
	assign reg_sel   = spdfq_pkg::reg_sel_t'(paddr[spdfq_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spdfq_pkg::REG_NUM_Q; i++) begin
				cap_q[i]   <= spdfq_pkg::CAP_RESET;
				delay_q[i] <= spdfq_pkg::DELAY_RESET;
			end
		end else if (apb_write) begin
			if (reg_sel < spdfq_pkg::REG_DELAY0) begin
				cap_q[reg_sel[spdfq_pkg::REG_IDX_W-1:0]] <= pwdata[spdfq_pkg::CAP_W-1:0];
			end else begin
				delay_q[reg_sel[spdfq_pkg::REG_IDX_W-1:0]] <=
					pwdata[spdfq_pkg::DELAY_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel < spdfq_pkg::REG_DELAY0) begin
			prdata = spdfq_pkg::APB_DATA_W'(cap_q[reg_sel[spdfq_pkg::REG_IDX_W-1:0]]);
		end else begin
			prdata = spdfq_pkg::APB_DATA_W'(delay_q[reg_sel[spdfq_pkg::REG_IDX_W-1:0]]);
		end
	end

	// sequencer and queue state
	state_t               state_q;
	logic [QW-1:0]        scan_q;
	logic                 remove_q;
	spdfq_pkg::rsp_item_t res_q;
	spdfq_pkg::rsp_item_t out_q;
	logic                 out_valid_q;
	logic [PTR_W-1:0]     head_q [NUM_PRIORITIES];
	logic [PTR_W-1:0]     tail_q [NUM_PRIORITIES];
	logic [OCC_W-1:0]     occ_q  [NUM_PRIORITIES];
	logic [TIME_WIDTH-1:0] time_q;

	spdfq_pkg::req_item_t item;
	logic                 accept;
	logic                 out_free;
	logic [QW-1:0]        enq_prio;
	logic [QW-1:0]        qsel;
	logic [PTR_W-1:0]     head_sel;
	logic [PTR_W-1:0]     tail_sel;
	logic [OCC_W-1:0]     occ_sel;
	logic                 port_ok;
	logic                 full;
	logic                 enq_write;
	logic [SUM_W-1:0]     release_sum;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [MEM_W-1:0]     wdata;
	logic [MEM_W-1:0]     rdata;
	logic [spdfq_pkg::HANDLE_W-1:0] rd_handle;
	logic [TIME_WIDTH-1:0] rd_time;
	logic                 scan_last;
	logic                 eligible;

	assign item      = req.data;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	if (NUM_PRIORITIES == 3) begin : g_mod3
		logic [4:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		assign s1 = 5'(item.tag_priority[7:4]) + 5'(item.tag_priority[3:0]);
		assign s2 = 4'(s1[4:2]) + 4'(s1[1:0]);
		assign s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
		assign enq_prio = (s3 >= 3'd3) ? QW'(s3 - 3'd3) : QW'(s3);
	end else begin : g_mask
		assign enq_prio = item.tag_priority[QW-1:0];
	end

	assign qsel     = (state_q == S_IDLE) ? enq_prio : scan_q;
	assign head_sel = head_q[qsel];
	assign tail_sel = tail_q[qsel];
	assign occ_sel  = occ_q[qsel];

	assign port_ok = {1'b0, item.port} < PORT_CW'(NUM_PORTS);
	assign full    = (CMP_W'(occ_sel) >= CMP_W'(cap_q[spdfq_pkg::REG_IDX_W'(enq_prio)]))
		|| (occ_sel == OCC_W'(QUEUE_DEPTH));
	assign enq_write = accept && (item.cmd == spdfq_pkg::CMD_ENQUEUE) && item.has_tag
		&& port_ok && !full;

	assign release_sum = SUM_W'(time_q)
		+ SUM_W'(delay_q[spdfq_pkg::REG_IDX_W'(enq_prio)]);
	assign wdata = {item.packet_handle, release_sum[TIME_WIDTH-1:0]};
	assign waddr = ADDR_W'(enq_prio) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_sel);
	assign raddr = ADDR_W'(scan_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_sel);

	spdfq_mem #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (MEM_W)
	) u_mem (
		.clk   (clk),
		.we    (enq_write),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_handle = rdata[MEM_W-1:TIME_WIDTH];
	assign rd_time   = rdata[TIME_WIDTH-1:0];
	assign scan_last = (scan_q == QW'(NUM_PRIORITIES - 1));
	assign eligible  = rd_time <= time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			remove_q    <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			time_q      <= '0;
			for (int i = 0; i < NUM_PRIORITIES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			if (out_valid_q && rsp.ready && (state_q != S_PUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.cmd)
							spdfq_pkg::CMD_TICK: begin
								time_q  <= time_q + 1'b1;
								res_q   <= '{spdfq_pkg::ST_TICK_DONE, '0, '0};
								state_q <= S_PUT;
							end
							spdfq_pkg::CMD_ENQUEUE: begin
								if (!item.has_tag || !port_ok) begin
									res_q <= '{spdfq_pkg::ST_REJECTED, '0, '0};
								end else if (full) begin
									res_q <= '{spdfq_pkg::ST_DROPPED, '0,
										spdfq_pkg::OPRIO_W'(enq_prio)};
								end else begin
									res_q <= '{spdfq_pkg::ST_ACCEPTED, '0,
										spdfq_pkg::OPRIO_W'(enq_prio)};
									tail_q[enq_prio]   <=
										(tail_sel == PTR_W'(QUEUE_DEPTH - 1)) ?
										'0 : tail_sel + 1'b1;
									occ_q[enq_prio]    <= occ_sel + 1'b1;
								end
								state_q <= S_PUT;
							end
							spdfq_pkg::CMD_DEQUEUE, spdfq_pkg::CMD_PEEK: begin
								res_q    <= '0;
								remove_q <= (item.cmd == spdfq_pkg::CMD_DEQUEUE);
								scan_q   <= '0;
								state_q  <= S_READ;
							end
						endcase
					end
				end
				S_READ: begin
					if (occ_sel != '0) begin
						state_q <= S_CHECK;
					end else if (scan_last) begin
						res_q.status <= spdfq_pkg::ST_NONE;
						state_q      <= S_PUT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_CHECK: begin
					if (eligible) begin
						res_q.status       <= spdfq_pkg::ST_GIVEN;
						res_q.out_handle   <= rd_handle;
						res_q.out_priority <= spdfq_pkg::OPRIO_W'(scan_q);
						if (remove_q) begin
							head_q[scan_q] <= (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ?
								'0 : head_sel + 1'b1;
							occ_q[scan_q]  <= occ_sel - 1'b1;
						end
						state_q <= S_PUT;
					end else if (scan_last) begin
						res_q.status <= spdfq_pkg::ST_NONE;
						state_q      <= S_PUT;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* tb/sv/spdfq_checker.sv */
module spdfq_checker
	import spdfq_pkg::*;
#(
	parameter int NUM_PRIORITIES = 4,
	parameter int NUM_PORTS      = 16,
	parameter int QUEUE_DEPTH    = 64,
	parameter int TIME_WIDTH     = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	spdfq_req_if                       req,
	spdfq_rsp_if                       rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	input  wire logic                  pready,
	output int                         failures,
	output int                         pending
);

	typedef struct packed {
		logic [HANDLE_W-1:0]   handle;
		logic [TIME_WIDTH-1:0] due;
	} held_entry_t;

	held_entry_t           held[NUM_PRIORITIES][$];
	logic [CAP_W-1:0]      cap_reg[REG_NUM_Q];
	logic [DELAY_W-1:0]    delay_reg[REG_NUM_Q];
	logic [TIME_WIDTH-1:0] now_ticks;
	rsp_item_t             owed_rsp[$];
	rsp_item_t             want;
	reg_sel_t              sel;
	int                    bad_results = 0;
	int                    owed_count = 0;

	assign failures = bad_results;
	assign pending  = owed_count;

	function automatic rsp_item_t serve_request(input req_item_t it);
		rsp_item_t   r;
		held_entry_t e;
		int          q;
		int          limit;
		bit          found;
		r.status       = ST_NONE;
		r.out_handle   = '0;
		r.out_priority = '0;
		found          = 1'b0;
		case (it.cmd)
			CMD_TICK: begin
				now_ticks = now_ticks + 1'b1;
				r.status  = ST_TICK_DONE;
			end
			CMD_ENQUEUE: begin
				if (!it.has_tag || it.port >= NUM_PORTS) begin
					r.status = ST_REJECTED;
				end else begin
					q              = int'(it.tag_priority) % NUM_PRIORITIES;
					limit          = (cap_reg[q] > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cap_reg[q]);
					r.out_priority = OPRIO_W'(q);
					if (held[q].size() >= limit) begin
						r.status = ST_DROPPED;
					end else begin
						e.handle = it.packet_handle;
						e.due    = now_ticks + TIME_WIDTH'(delay_reg[q]);
						held[q].push_back(e);
						r.status = ST_ACCEPTED;
					end
				end
			end
			default: begin
				for (q = 0; q < NUM_PRIORITIES; q++) begin
					if (!found && held[q].size() != 0 && held[q][0].due <= now_ticks) begin
						found          = 1'b1;
						r.status       = ST_GIVEN;
						r.out_handle   = held[q][0].handle;
						r.out_priority = OPRIO_W'(q);
						if (it.cmd == CMD_DEQUEUE) begin
							held[q].delete(0);
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < REG_NUM_Q; q++) begin
				cap_reg[q]   = CAP_RESET;
				delay_reg[q] = DELAY_RESET;
			end
			for (int q = 0; q < NUM_PRIORITIES; q++) begin
				held[q].delete();
			end
			now_ticks = '0;
			owed_rsp.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				sel = reg_sel_t'(paddr[APB_ADDR_W-1:2]);
				if (sel <= REG_CAPACITY3) begin
					cap_reg[sel[REG_IDX_W-1:0]] = pwdata[CAP_W-1:0];
				end else begin
					delay_reg[sel[REG_IDX_W-1:0]] = pwdata[DELAY_W-1:0];
				end
			end
			if (req.valid && req.ready) begin
				owed_rsp.push_back(serve_request(req.data));
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_rsp.size() == 0) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("unexpected result: status %0d handle %h prio %0d",
							rsp.data.status, rsp.data.out_handle, rsp.data.out_priority);
					end
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.data.status !== want.status || rsp.data.out_handle !== want.out_handle ||
						rsp.data.out_priority !== want.out_priority) begin
						bad_results++;
						if (bad_results <= 10) begin
							$display("result mismatch: want status %0d handle %h prio %0d, got status %0d handle %h prio %0d",
								want.status, want.out_handle, want.out_priority,
								rsp.data.status, rsp.data.out_handle, rsp.data.out_priority);
						end
					end
				end
			end
		end
		owed_count = owed_rsp.size();
	end

endmodule

/* tb/sv/strict_priority_delayed_fifo_queues_core_test.sv */
module strict_priority_delayed_fifo_queues_core_test;
	import spdfq_pkg::*;

	localparam int PRIOS = 4;
	localparam int PORTS = 16;
	localparam int DEPTH = 64;
	localparam int TW    = 32;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    failures;
	int                    pending;
	bit                    hold_off;
	int                    burst_left;

	spdfq_req_if req_ch();
	spdfq_rsp_if rsp_ch();

	strict_priority_delayed_fifo_queues_core #(
		.NUM_PRIORITIES(PRIOS),
		.NUM_PORTS(PORTS),
		.QUEUE_DEPTH(DEPTH),
		.TIME_WIDTH(TW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	spdfq_checker #(
		.NUM_PRIORITIES(PRIOS),
		.NUM_PORTS(PORTS),
		.QUEUE_DEPTH(DEPTH),
		.TIME_WIDTH(TW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.failures(failures),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic req_item_t noise_item(input cmd_t c);
		req_item_t it;
		it.cmd           = c;
		it.has_tag       = 1'($urandom_range(0, 1));
		it.tag_priority  = 8'($urandom_range(0, 255));
		it.port          = 16'($urandom_range(0, 65535));
		it.packet_handle = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic req_item_t random_item(input int w_tick, input int w_enq, input int w_deq);
		req_item_t it;
		int        r;
		r = $urandom_range(0, 99);
		if (r < w_tick) begin
			return noise_item(CMD_TICK);
		end
		if (r < w_tick + w_enq) begin
			it         = noise_item(CMD_ENQUEUE);
			it.has_tag = ($urandom_range(0, 15) != 0);
			if ($urandom_range(0, 9) != 0) begin
				it.port = 16'($urandom_range(0, PORTS - 1));
			end
			return it;
		end
		if (r < w_tick + w_enq + w_deq) begin
			return noise_item(CMD_DEQUEUE);
		end
		return noise_item(CMD_PEEK);
	endfunction

	task automatic offer(input req_item_t it);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data  = it;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic push(input req_item_t it);
		if (burst_left == 0) begin
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
			burst_left = $urandom_range(1, 24);
		end
		offer(it);
		burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic reg_write(input reg_sel_t sel, input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {sel, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_release();
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_queue(input int q, input int cap, input int dly, input bit noisy);
		logic [APB_DATA_W-1:0] cap_word;
		logic [APB_DATA_W-1:0] dly_word;
		cap_word = APB_DATA_W'(cap);
		dly_word = APB_DATA_W'(dly);
		if (noisy) begin
			cap_word = cap_word | ($urandom() & ~((32'd1 << CAP_W) - 32'd1));
			dly_word = dly_word | ($urandom() & ~((32'd1 << DELAY_W) - 32'd1));
		end
		reg_write(reg_sel_t'(q), cap_word);
		reg_write(reg_sel_t'(REG_DELAY0 + q), dly_word);
	endtask

	task automatic run_random(input int n, input int w_tick, input int w_enq, input int w_deq,
		input int hold_at);
		for (int k = 0; k < n; k++) begin
			if (k == hold_at) begin
				hold_off = 1'b1;
			end
			push(random_item(w_tick, w_enq, w_deq));
		end
	endtask

	initial begin
		int        span;
		int        mode;
		int        hold_left;
		logic [7:0] beat;
		span          = 0;
		mode          = 0;
		hold_left     = 0;
		beat          = 8'b1011_0010;
		rsp_ch.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off && hold_left == 0) begin
				hold_left = 400;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
				if (hold_left == 0) begin
					hold_off = 1'b0;
				end
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 96);
				end
				span--;
				beat = {beat[6:0], beat[7]};
				case (mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready = 1'($urandom_range(0, 1));
					default: rsp_ch.ready = beat[0];
				endcase
			end
		end
	end

	initial begin
		req_item_t it;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		hold_off     = 1'b0;
		burst_left   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push(req_item_t'{CMD_DEQUEUE, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF});
		push(req_item_t'{CMD_PEEK, 1'b0, 8'h00, 16'h0000, 16'h0000});
		push(req_item_t'{CMD_TICK, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF});
		push(req_item_t'{CMD_ENQUEUE, 1'b0, 8'h00, 16'h0000, 16'h1234});
		push(req_item_t'{CMD_ENQUEUE, 1'b1, 8'h01, 16'd16, 16'h2345});
		push(req_item_t'{CMD_ENQUEUE, 1'b1, 8'h02, 16'hFFFF, 16'h3456});
		push(req_item_t'{CMD_ENQUEUE, 1'b1, 8'hFF, 16'd15, 16'hFFFF});
		push(req_item_t'{CMD_ENQUEUE, 1'b1, 8'h00, 16'd0, 16'h0000});
		push(req_item_t'{CMD_ENQUEUE, 1'b1, 8'h81, 16'd7, 16'hA5A5});
		push(req_item_t'{CMD_ENQUEUE, 1'b1, 8'h7E, 16'd8, 16'h5A5A});
		push(req_item_t'{CMD_PEEK, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF});
		push(req_item_t'{CMD_DEQUEUE, 1'b0, 8'h00, 16'h0000, 16'h0000});
		for (int k = 0; k < 66; k++) begin
			it                   = noise_item(CMD_ENQUEUE);
			it.has_tag           = 1'b1;
			it.tag_priority[1:0] = 2'b00;
			it.port              = 16'($urandom_range(0, PORTS - 1));
			push(it);
		end
		repeat (999) push(noise_item(CMD_TICK));
		push(noise_item(CMD_DEQUEUE));
		push(noise_item(CMD_TICK));
		push(noise_item(CMD_PEEK));
		push(noise_item(CMD_DEQUEUE));
		push(noise_item(CMD_DEQUEUE));
		push(noise_item(CMD_DEQUEUE));
		drain();

		set_queue(0, 127, 0, 1'b0);
		set_queue(1, 0, 1, 1'b0);
		set_queue(2, 3, 4, 1'b0);
		set_queue(3, 64, 2, 1'b0);
		apb_release();
		run_random(110, 20, 45, 25, 40);
		drain();

		set_queue(0, 2, 3, 1'b0);
		set_queue(1, 64, 0, 1'b0);
		set_queue(2, 1, 0, 1'b0);
		set_queue(3, 127, 1, 1'b0);
		apb_release();
		run_random(100, 25, 30, 35, -1);
		drain();

		set_queue(0, 64, 0, 1'b1);
		set_queue(1, 5, 2, 1'b1);
		set_queue(2, 0, 1, 1'b1);
		set_queue(3, 64, 1000000, 1'b1);
		apb_release();
		run_random(100, 25, 40, 25, -1);
		drain();

		repeat (20) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* strict_priority_delayed_fifo_queues_core.f */
design/spdfq_pkg.sv
design/spdfq_ifs.sv
design/spdfq_mem.sv
design/strict_priority_delayed_fifo_queues_core.sv
tb/sv/spdfq_checker.sv
tb/sv/strict_priority_delayed_fifo_queues_core_test.sv
